### sv/sunp_pkg.sv
// ----------------------------------------------------------------------------
// sunp_pkg
// Shared types, constants and character-class functions for the strict
// unsigned number parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sunp_pkg;

    // Width of a character code on the input port
    localparam int CHAR_BITS = 16;
    // Width of the parsed value
    localparam int NUM_BITS  = 64;
    // Accumulator width with room for one extra hex digit of overflow
    localparam int WIDE_BITS = NUM_BITS + 4;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CH_SPACE = CHAR_BITS'('h20);
    localparam logic [CHAR_BITS-1:0] CH_TAB   = CHAR_BITS'('h09);
    localparam logic [CHAR_BITS-1:0] CH_LF    = CHAR_BITS'('h0A);
    localparam logic [CHAR_BITS-1:0] CH_VT    = CHAR_BITS'('h0B);
    localparam logic [CHAR_BITS-1:0] CH_FF    = CHAR_BITS'('h0C);
    localparam logic [CHAR_BITS-1:0] CH_CR    = CHAR_BITS'('h0D);
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = CHAR_BITS'('h30);
    localparam logic [CHAR_BITS-1:0] CH_NINE  = CHAR_BITS'('h39);
    localparam logic [CHAR_BITS-1:0] CH_UC_A  = CHAR_BITS'('h41);
    localparam logic [CHAR_BITS-1:0] CH_UC_F  = CHAR_BITS'('h46);
    localparam logic [CHAR_BITS-1:0] CH_LC_A  = CHAR_BITS'('h61);
    localparam logic [CHAR_BITS-1:0] CH_LC_F  = CHAR_BITS'('h66);

    // Parse phase
    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_DIGIT = 2'd1,
        PH_TRAIL = 2'd2,
        PH_FAIL  = 2'd3
    } t_phase;

    // Decoded digit
    typedef struct packed {
        logic       is_digit;
        logic [3:0] value;
    } t_digit;

    // Whitespace test: space, tab, CR, LF, FF, VT
    function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_LF) || (c == CH_FF) || (c == CH_VT);
    endfunction

    // Digit decode in the selected base
    function automatic t_digit digit_of(input logic [CHAR_BITS-1:0] c,
                                        input logic hex);
        t_digit d;
        d.is_digit = 1'b0;
        d.value    = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.is_digit = 1'b1;
            d.value    = 4'(c - CH_ZERO);
        end else if (hex && c >= CH_LC_A && c <= CH_LC_F) begin
            d.is_digit = 1'b1;
            d.value    = 4'(c - CH_LC_A) + 4'd10;
        end else if (hex && c >= CH_UC_A && c <= CH_UC_F) begin
            d.is_digit = 1'b1;
            d.value    = 4'(c - CH_UC_A) + 4'd10;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### sv/strict_unsigned_number_parser.sv
// ----------------------------------------------------------------------------
// strict_unsigned_number_parser
// Parses a text, one character per word, into an unsigned 64-bit number in
// decimal or hexadecimal, with leading and trailing whitespace skipped.
// ----------------------------------------------------------------------------
// One character word is taken per cycle. A word is registered on input and
// processed out of the input register by a single pass of decode, multiply
// by ten or sixteen (shift and add) and overflow check against the phase and
// accumulator registers; the word marked last then goes from the input
// register into the result register. Input stalls only while a last word
// waits for a result register that is still full and stalled downstream.
// The base register must be written only while no text is in flight.
`timescale 1ns / 1ps
`default_nettype none

module strict_unsigned_number_parser (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [sunp_pkg::CHAR_BITS-1:0] i_char_code,
    input  wire logic                           i_char_present,
    input  wire logic                           i_last,
    // output channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_ok,
    output logic [sunp_pkg::NUM_BITS-1:0]       o_number
);

    // Base register
    logic r_base_hex;

    // Input register
    logic                           r_in_valid;
    logic [sunp_pkg::CHAR_BITS-1:0] r_char;
    logic                           r_present;
    logic                           r_last;

    // Parse state
    sunp_pkg::t_phase              r_phase, n_phase;
    logic [sunp_pkg::NUM_BITS-1:0] r_acc, n_acc;

    // Result register
    logic                          r_out_valid;
    logic                          r_ok, n_ok;
    logic [sunp_pkg::NUM_BITS-1:0] r_number, n_number;

    // Handshake and datapath signals
    logic                           out_free;
    logic                           s1_go;
    logic                           in_take;
    logic                           hex;
    logic                           blank;
    sunp_pkg::t_digit               dig;
    logic [sunp_pkg::WIDE_BITS-1:0] acc_wide;
    logic [sunp_pkg::WIDE_BITS-1:0] prod;
    logic [sunp_pkg::WIDE_BITS-1:0] sum;
    logic                           ovf;
    sunp_pkg::t_phase               ch_phase;
    logic                           ok_now;

    // Handshake: a last word needs the result register, others pass freely
    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_in_valid && (!r_last || out_free);
    assign o_stall  = r_in_valid && !s1_go;
    assign in_take  = i_valid && !o_stall;

    // Base register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_hex <= 1'b0;
        end else if (i_cfg_we) begin
            r_base_hex <= i_cfg_wdata;
        end
    end

    // Input register: load on accept, drop once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char    <= i_char_code;
            r_present <= i_char_present;
            r_last    <= i_last;
        end
    end

    // Character classification and next accumulator value
    assign hex      = r_base_hex;
    assign blank    = sunp_pkg::is_blank(r_char);
    assign dig      = sunp_pkg::digit_of(r_char, hex);
    assign acc_wide = {4'd0, r_acc};
    assign prod     = hex ? (acc_wide << 4) : ((acc_wide << 3) + (acc_wide << 1));
    assign sum      = prod + sunp_pkg::WIDE_BITS'(dig.value);
    assign ovf      = |sum[sunp_pkg::WIDE_BITS-1:sunp_pkg::NUM_BITS];

    // Phase after the character of the current word
    always_comb begin
        ch_phase = r_phase;
        if (r_present) begin
            unique case (r_phase)
                sunp_pkg::PH_LEAD: begin
                    if (blank)             ch_phase = sunp_pkg::PH_LEAD;
                    else if (dig.is_digit) ch_phase = sunp_pkg::PH_DIGIT;
                    else                   ch_phase = sunp_pkg::PH_FAIL;
                end
                sunp_pkg::PH_DIGIT: begin
                    if (dig.is_digit)      ch_phase = ovf ? sunp_pkg::PH_FAIL
                                                          : sunp_pkg::PH_DIGIT;
                    else if (blank)        ch_phase = sunp_pkg::PH_TRAIL;
                    else                   ch_phase = sunp_pkg::PH_FAIL;
                end
                sunp_pkg::PH_TRAIL: begin
                    if (!blank)            ch_phase = sunp_pkg::PH_FAIL;
                end
                sunp_pkg::PH_FAIL: begin
                    ch_phase = sunp_pkg::PH_FAIL;
                end
                default: ch_phase = sunp_pkg::PH_FAIL;
            endcase
        end
    end

    // Next phase: back to the start after a last word
    always_comb begin
        n_phase = r_phase;
        if (s1_go) begin
            n_phase = r_last ? sunp_pkg::PH_LEAD : ch_phase;
        end
    end

    // Accumulator update and result value
    always_comb begin
        n_acc = r_acc;
        if (r_present && dig.is_digit) begin
            if (r_phase == sunp_pkg::PH_LEAD) begin
                n_acc = sunp_pkg::NUM_BITS'(dig.value);
            end else if (r_phase == sunp_pkg::PH_DIGIT && !ovf) begin
                n_acc = sum[sunp_pkg::NUM_BITS-1:0];
            end
        end
        ok_now   = (ch_phase == sunp_pkg::PH_DIGIT) || (ch_phase == sunp_pkg::PH_TRAIL);
        n_ok     = ok_now;
        n_number = ok_now ? n_acc : '0;
        if (!s1_go) begin
            n_acc = r_acc;
        end else if (r_last) begin
            n_acc = '0;
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sunp_pkg::PH_LEAD;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    // Result register: load on a last word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_last) begin
            r_ok     <= n_ok;
            r_number <= n_number;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_ok     = r_ok;
    assign o_number = r_number;

    // A failed result carries a zero number
    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> r_number == '0)
        else $error("failed result with non-zero number");

    // The start phase always has an empty accumulator
    a_lead_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sunp_pkg::PH_LEAD |-> r_acc == '0)
        else $error("accumulator not clear in leading phase");

    // A last word returns the parser to its start phase
    a_last_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_last |=> r_phase == sunp_pkg::PH_LEAD)
        else $error("parser not restarted after last word");

    // Failure sticks until the end of the text
    a_fail_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sunp_pkg::PH_FAIL && !(s1_go && r_last)
            |=> r_phase == sunp_pkg::PH_FAIL)
        else $error("failed phase left before end of text");

endmodule

`default_nettype wire
